>>> hw/rtl/tqs_pkg.sv
// ----------------------------------------------------------------------------
// tqs_pkg
// Shared types, widths and codes of the tone queue sequencer.
// ----------------------------------------------------------------------------
package tqs_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int EASE_STEPS_DEF  = 8;
   localparam int COUNT_W         = 6;
   localparam int DATA_W          = 16;
   localparam int PERIOD_W        = 15;
   localparam int FUNC_W          = 2;
   localparam int ACC_W           = 21;
   localparam int DIV_SHIFT       = 20;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK = 2'd0,
      FUNC_KEEP = 2'd1,
      FUNC_EASE = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   typedef struct packed {
      logic load;
      logic tick;
      logic keep;
      logic reject;
      logic ease_start;
      logic step_load;
      logic div_acc;
      logic ease_push;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     ease_room;
      logic     div_done;
      logic     last_step;
   } sts_type;

endpackage

>>> hw/rtl/tqs_if.sv
// ----------------------------------------------------------------------------
// tqs_if
// Valid/ready channels of the tone queue sequencer: request, response, csr.
// ----------------------------------------------------------------------------
interface tqs_req_if;
   logic                              valid;
   logic                              ready;
   logic [tqs_pkg::FUNC_W-1:0]        func;
   logic signed [tqs_pkg::DATA_W-1:0] duration_ms;
   logic [tqs_pkg::DATA_W-1:0]        freq_start;
   logic [tqs_pkg::DATA_W-1:0]        freq_end;

   modport source (output valid, func, duration_ms, freq_start, freq_end, input ready);
   modport sink   (input valid, func, duration_ms, freq_start, freq_end, output ready);
endinterface

interface tqs_rsp_if #(
   parameter int CountW = tqs_pkg::COUNT_W
);
   logic                       valid;
   logic                       ready;
   logic [tqs_pkg::DATA_W-1:0] tone_freq;
   logic [CountW-1:0]          queue_count;
   logic                       rejected;

   modport source (output valid, tone_freq, queue_count, rejected, input ready);
   modport sink   (input valid, tone_freq, queue_count, rejected, output ready);
endinterface

interface tqs_csr_if;
   logic                         valid;
   logic                         ready;
   logic [tqs_pkg::PERIOD_W-1:0] tick_period_ms;

   modport source (output valid, tick_period_ms, input ready);
   modport sink   (input valid, tick_period_ms, output ready);
endinterface

>>> hw/rtl/tqs_cdiv.sv
// ----------------------------------------------------------------------------
// tqs_cdiv
// Signed divide by EASE_STEPS, truncating toward zero. Three-stage pipeline:
// magnitude, reciprocal multiply, remainder correction and sign restore.
// ----------------------------------------------------------------------------
module tqs_cdiv #(
   parameter int EASE_STEPS = tqs_pkg::EASE_STEPS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [tqs_pkg::ACC_W-1:0] x,
   output logic                             done,
   output logic signed [tqs_pkg::ACC_W-1:0] q
);

   localparam int AccW   = tqs_pkg::ACC_W;
   localparam int ShiftW = tqs_pkg::DIV_SHIFT;
   localparam int ProdW  = AccW + ShiftW;
   localparam int Recip  = (1 << ShiftW) / EASE_STEPS;
   localparam int EaseW  = $clog2(EASE_STEPS + 1);
   localparam int BackW  = AccW + EaseW;

   logic [2:0]             vld_ff;
   logic [AccW-1:0]        mag_ff;
   logic [AccW-1:0]        mag2_ff;
   logic                   neg_ff;
   logic                   neg2_ff;
   logic [AccW-1:0]        q0_ff;
   logic signed [AccW-1:0] q_ff;
   logic [AccW-1:0]        mag_in;
   logic [ProdW-1:0]       prod;
   logic [BackW-1:0]       back;
   logic [BackW-1:0]       rem;
   logic [AccW-1:0]        qm;

   assign mag_in = x[AccW-1] ? AccW'(-x) : AccW'(x);
   assign prod   = ProdW'(mag_ff) * ProdW'(Recip);
   assign back   = BackW'(q0_ff) * BackW'(EASE_STEPS);
   assign rem    = BackW'(mag2_ff) - back;
   assign qm     = q0_ff + AccW'(rem >= BackW'(EASE_STEPS));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], start};
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= x[AccW-1];
      q0_ff   <= prod[ShiftW +: AccW];
      mag2_ff <= mag_ff;
      neg2_ff <= neg_ff;
      q_ff    <= neg2_ff ? -$signed(qm) : $signed(qm);
   end

   assign done = vld_ff[2];
   assign q    = q_ff;

endmodule

>>> hw/rtl/tqs_ctrl.sv
// ----------------------------------------------------------------------------
// tqs_ctrl
// Sequencer of the tone queue: decodes each word, steps the ramp writes and
// holds the response valid.
// ----------------------------------------------------------------------------
module tqs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  tqs_pkg::sts_type sts,
   output tqs_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_DUR_WAIT,
      S_ACC_DIV,
      S_ACC_WAIT,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_DECODE;
            end
            S_DECODE: begin
               if (sts.func == tqs_pkg::FUNC_EASE && sts.ease_room) begin
                  state_ff <= S_DUR_WAIT;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_DUR_WAIT: begin
               if (sts.div_done) state_ff <= S_ACC_DIV;
            end
            S_ACC_DIV: begin
               state_ff <= S_ACC_WAIT;
            end
            S_ACC_WAIT: begin
               if (sts.div_done) state_ff <= sts.last_step ? S_DONE : S_ACC_DIV;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE:     cmd.load = req_valid;
         S_DECODE: begin
            cmd.tick       = (sts.func == tqs_pkg::FUNC_TICK);
            cmd.keep       = (sts.func == tqs_pkg::FUNC_KEEP);
            cmd.ease_start = (sts.func == tqs_pkg::FUNC_EASE) && sts.ease_room;
            cmd.reject     = (sts.func == tqs_pkg::FUNC_EASE) && !sts.ease_room;
         end
         S_DUR_WAIT: cmd.step_load = sts.div_done;
         S_ACC_DIV:  cmd.div_acc   = 1'b1;
         S_ACC_WAIT: cmd.ease_push = sts.div_done;
         S_DONE:     cmd.rsp_load  = !rsp_valid_ff || rsp_ready;
         default:    cmd = '0;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/tqs_dpath.sv
// ----------------------------------------------------------------------------
// tqs_dpath
// Queue memory, pointers, tone state, ramp accumulator and response register
// of the tone queue sequencer.
// ----------------------------------------------------------------------------
module tqs_dpath #(
   parameter int QUEUE_DEPTH = tqs_pkg::QUEUE_DEPTH_DEF,
   parameter int EASE_STEPS  = tqs_pkg::EASE_STEPS_DEF,
   parameter int CntW        = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tqs_pkg::cmd_type                    cmd,
   output tqs_pkg::sts_type                    sts,
   input  logic [tqs_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [tqs_pkg::DATA_W-1:0]   req_duration_ms,
   input  logic [tqs_pkg::DATA_W-1:0]          req_freq_start,
   input  logic [tqs_pkg::DATA_W-1:0]          req_freq_end,
   input  logic                                csr_valid,
   input  logic [tqs_pkg::PERIOD_W-1:0]        csr_tick_period_ms,
   output logic [tqs_pkg::DATA_W-1:0]          rsp_tone_freq,
   output logic [CntW-1:0]                     rsp_queue_count,
   output logic                                rsp_rejected
);

   localparam int DataW = tqs_pkg::DATA_W;
   localparam int AccW  = tqs_pkg::ACC_W;
   localparam int PtrW  = $clog2(QUEUE_DEPTH);
   localparam int StepW = $clog2(EASE_STEPS);
   localparam int WordW = 2 * DataW;

   logic [WordW-1:0]             mem [QUEUE_DEPTH];
   logic [WordW-1:0]             rd_ff;
   logic                         wr_en;
   logic [PtrW-1:0]              wr_addr;
   logic [WordW-1:0]             wr_data;

   logic [tqs_pkg::FUNC_W-1:0]   func_ff;
   logic [DataW-1:0]             dur_ff;
   logic [DataW-1:0]             f1_ff;
   logic [DataW-1:0]             f2_ff;
   logic [PtrW-1:0]              head_ff;
   logic [PtrW-1:0]              tail_ff;
   logic [CntW-1:0]              count_ff;
   logic [DataW-1:0]             cur_ff;
   logic                         sound_ff;
   logic [tqs_pkg::PERIOD_W-1:0] period_ff;
   logic                         rej_ff;
   logic [StepW-1:0]             step_ff;
   logic signed [AccW-1:0]       acc_ff;
   logic [DataW-1:0]             step_t_ff;
   logic [DataW-1:0]             tone_ff;
   logic [CntW-1:0]              qcnt_ff;
   logic                         rejo_ff;

   logic [PtrW-1:0]              head_in;
   logic [PtrW-1:0]              tail_in;
   logic signed [DataW-1:0]      rd_time;
   logic [DataW-1:0]             rd_freq;
   logic                         keep_room;
   logic                         queue_busy;
   logic                         head_live;
   logic signed [AccW-1:0]       diff;
   logic signed [AccW-1:0]       div_x;
   logic                         div_start;
   logic                         div_done;
   logic signed [AccW-1:0]       div_q;
   logic [DataW-1:0]             ramp_freq;

   assign head_in    = (head_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_in    = (tail_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign rd_time    = $signed(rd_ff[WordW-1:DataW]);
   assign rd_freq    = rd_ff[DataW-1:0];
   assign keep_room  = (count_ff < CntW'(QUEUE_DEPTH));
   assign queue_busy = (count_ff != '0);
   assign head_live  = (rd_time > 0);
   assign diff       = AccW'($signed({1'b0, f2_ff})) - AccW'($signed({1'b0, f1_ff}));
   assign div_x      = cmd.ease_start ? {{(AccW-DataW){dur_ff[DataW-1]}}, dur_ff} : acc_ff;
   assign div_start  = cmd.ease_start | cmd.div_acc;
   assign ramp_freq  = f1_ff + div_q[DataW-1:0];

   tqs_cdiv #(
      .EASE_STEPS (EASE_STEPS)
   ) u_cdiv (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .x     (div_x),
      .done  (div_done),
      .q     (div_q)
   );

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = tail_ff;
      wr_data = {step_t_ff, ramp_freq};
      if (cmd.tick && queue_busy && head_live) begin
         wr_en   = 1'b1;
         wr_addr = head_ff;
         wr_data = {rd_ff[WordW-1:DataW] - DataW'(period_ff), rd_freq};
      end else if (cmd.keep && keep_room) begin
         wr_en   = 1'b1;
         wr_data = {dur_ff, f1_ff};
      end else if (cmd.ease_push) begin
         wr_en   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         cur_ff    <= '0;
         sound_ff  <= 1'b1;
         period_ff <= tqs_pkg::PERIOD_W'(1);
         rej_ff    <= 1'b0;
         step_ff   <= '0;
      end else begin
         if (csr_valid) period_ff <= csr_tick_period_ms;
         if (cmd.load) rej_ff <= 1'b0;
         if (cmd.tick) begin
            if (queue_busy) begin
               if (head_live) begin
                  cur_ff <= rd_freq;
               end else begin
                  head_ff  <= head_in;
                  count_ff <= count_ff - 1'b1;
               end
            end else if (sound_ff) begin
               sound_ff <= 1'b0;
               cur_ff   <= '0;
            end
         end
         if (cmd.keep) begin
            if (keep_room) begin
               tail_ff  <= tail_in;
               count_ff <= count_ff + 1'b1;
               sound_ff <= 1'b1;
            end else begin
               rej_ff <= 1'b1;
            end
         end
         if (cmd.reject) rej_ff <= 1'b1;
         if (cmd.ease_start) begin
            sound_ff <= 1'b1;
            step_ff  <= '0;
         end
         if (cmd.ease_push) begin
            tail_ff  <= tail_in;
            count_ff <= count_ff + 1'b1;
            step_ff  <= step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         dur_ff  <= req_duration_ms;
         f1_ff   <= req_freq_start;
         f2_ff   <= req_freq_end;
      end
      if (cmd.ease_start) acc_ff <= '0;
      if (cmd.ease_push) acc_ff <= acc_ff + diff;
      if (cmd.step_load) step_t_ff <= div_q[DataW-1:0];
      if (cmd.rsp_load) begin
         tone_ff <= cur_ff;
         qcnt_ff <= count_ff;
         rejo_ff <= rej_ff;
      end
   end

   assign sts.func      = tqs_pkg::func_type'(func_ff);
   assign sts.ease_room = ({1'b0, count_ff} + (CntW+1)'(EASE_STEPS - 1))
                          <= (CntW+1)'(QUEUE_DEPTH);
   assign sts.div_done  = div_done;
   assign sts.last_step = (step_ff == StepW'(EASE_STEPS - 2));

   assign rsp_tone_freq   = tone_ff;
   assign rsp_queue_count = qcnt_ff;
   assign rsp_rejected    = rejo_ff;

endmodule

>>> hw/rtl/tone_queue_sequencer.sv
// ----------------------------------------------------------------------------
// tone_queue_sequencer
// Buzzer tone sequencer over a circular queue of duration/frequency entries.
//
// req_bus takes one word per command: tick, keep (queue one tone) or ease
// (queue EASE_STEPS-1 ramped tones). rsp_bus returns one word per command
// with the driven tone, the queue fill and a rejected flag for a push that
// does not fit. csr_bus writes the tick period and is always ready; write
// it only while the block is idle.
// One command is in flight at a time. Tick, keep and the unused code go
// through decode straight to the response; ease first divides the duration,
// then runs each ramp step through the three-stage divide pipeline.
// A new command is accepted in the cycle after the response is loaded, even
// while the response still waits on rsp_bus.ready; a stalled response holds
// and the next result waits in the sequencer until it is taken.
// Reset empties the queue, silences the tone, arms the on-flag and sets the
// tick period to 1. Queue entries hold no reset value.
// ----------------------------------------------------------------------------
module tone_queue_sequencer #(
   parameter int QUEUE_DEPTH = tqs_pkg::QUEUE_DEPTH_DEF,
   parameter int EASE_STEPS  = tqs_pkg::EASE_STEPS_DEF
) (
   input logic       clock,
   input logic       reset,
   tqs_req_if.sink   req_bus,
   tqs_rsp_if.source rsp_bus,
   tqs_csr_if.sink   csr_bus
);

   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   tqs_pkg::cmd_type cmd;
   tqs_pkg::sts_type sts;

   assign csr_bus.ready = 1'b1;

   tqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tqs_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .EASE_STEPS  (EASE_STEPS),
      .CntW        (CntW)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_func           (req_bus.func),
      .req_duration_ms    (req_bus.duration_ms),
      .req_freq_start     (req_bus.freq_start),
      .req_freq_end       (req_bus.freq_end),
      .csr_valid          (csr_bus.valid),
      .csr_tick_period_ms (csr_bus.tick_period_ms),
      .rsp_tone_freq      (rsp_bus.tone_freq),
      .rsp_queue_count    (rsp_bus.queue_count),
      .rsp_rejected       (rsp_bus.rejected)
   );

endmodule

>>> hw/rtl/tqs_checker.sv
// ----------------------------------------------------------------------------
// tqs_checker
// Port-level checks of the tone queue sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module tqs_checker #(
   parameter int QUEUE_DEPTH = tqs_pkg::QUEUE_DEPTH_DEF,
   parameter int EASE_STEPS  = tqs_pkg::EASE_STEPS_DEF,
   parameter int CntW        = $clog2(QUEUE_DEPTH + 1)
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [tqs_pkg::DATA_W-1:0] rsp_tone_freq,
   input logic [CntW-1:0]            rsp_queue_count,
   input logic                       rsp_rejected
);

   localparam int SumW = CntW + 1;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tone_freq)
         && $stable(rsp_queue_count) && $stable(rsp_rejected))
      else $error("response word changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while one is in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_queue_count <= CntW'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected
         |-> (SumW'(rsp_queue_count) + SumW'(EASE_STEPS - 1)) > SumW'(QUEUE_DEPTH))
      else $error("push refused with room in the queue");

endmodule

bind tone_queue_sequencer tqs_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH),
   .EASE_STEPS  (EASE_STEPS),
   .CntW        (CntW)
) u_tqs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_tone_freq   (rsp_bus.tone_freq),
   .rsp_queue_count (rsp_bus.queue_count),
   .rsp_rejected    (rsp_bus.rejected)
);
